### rtl/hadamard_feedback_delay_reverb_assert.svh
// Assertion macros for the reverb block
`ifndef HADAMARD_FEEDBACK_DELAY_REVERB_ASSERT_SVH
`define HADAMARD_FEEDBACK_DELAY_REVERB_ASSERT_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define HFDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Assert that an expression holds in every cycle out of reset.
`define HFDR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

### rtl/hfdr_pkg.sv
// ----------------------------------------------------------------------------
// hfdr_pkg
// Shared constants and helpers of the feedback delay network reverb.
// ----------------------------------------------------------------------------
package hfdr_pkg;
  localparam int NUM_LINES_DEF   = 16;
  localparam int MAX_DELAY_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LEN_BITS        = 12;
  localparam int IDX_BITS        = 6;
  localparam int GAIN_BITS       = 17;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // round(sqrt(x)) for x = 2**32 / n, giving round(65536 / sqrt(n)) at elaboration
  function automatic int tap_gain(input longint x);
    longint r;
    begin
      r = 0;
      while ((r + 1) * (r + 1) <= x) r++;
      if (x - r * r > r) r++;
      return int'(r);
    end
  endfunction
endpackage

### rtl/hadamard_feedback_delay_reverb.sv
// A sample item passes through S_READ, S_MIX, S_WRITE and S_DONE, paced by one delay-memory
// port and one shared butterfly unit; a load item goes from S_IDLE straight to S_DONE. A new
// item is taken only once S_DONE has handed on its result and the block is back in S_IDLE.
// One item is in work at a time; the output register lets the next item enter while a result waits.
// After reset the memory is cleared, all NUM_LINES*2**clog2(MAX_DELAY) words (65536 default).
// ----------------------------------------------------------------------------
// hadamard_feedback_delay_reverb
// FDN reverb: memory-held delay lines mixed by a sequential Walsh-Hadamard transform.
// ----------------------------------------------------------------------------
module hadamard_feedback_delay_reverb
  import hfdr_pkg::*;
#(
  parameter int NUM_LINES   = NUM_LINES_DEF,
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [SAMPLE_BITS-1:0] in_in_sample,
  input  logic [IDX_BITS-1:0]           in_line_index,
  input  logic [LEN_BITS-1:0]           in_delay_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_out_sample,
  output logic                          out_saturated
);
  localparam int LB    = $clog2(NUM_LINES);
  localparam int PB    = $clog2(MAX_DELAY);
  localparam int AB    = LB + PB;
  localparam int DEPTH = NUM_LINES << PB;
  localparam int WB    = SAMPLE_BITS + LB + 2;
  localparam int ACCB  = SAMPLE_BITS + LB + 2;
  localparam longint GAIN_SQ = (64'sd1 <<< 32) / NUM_LINES;
  localparam int GAIN  = tap_gain(GAIN_SQ);
  localparam int DEFD  = (4095 < MAX_DELAY - 1) ? 4095 : MAX_DELAY - 1;
  localparam logic [PB-1:0] DEF_LEN = PB'(DEFD);
  localparam logic [PB-1:0] MAX_LEN = PB'(MAX_DELAY - 1);
  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_MIX, S_WRITE, S_DONE
  } state_t;

  // Delay memory, one port
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [AB-1:0]                 mem_addr;
  logic                          mem_we;
  logic signed [SAMPLE_BITS-1:0] mem_wdata;
  logic signed [SAMPLE_BITS-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= mem[mem_addr];
  end

  // Per-line pointers and lengths
  logic [PB-1:0] rpos_r [NUM_LINES];
  logic [PB-1:0] wpos_r [NUM_LINES];
  logic [PB-1:0] len_r  [NUM_LINES];
  // Mix working set
  logic signed [WB-1:0] mix_r [NUM_LINES];

  state_t                        state_r;
  logic [AB-1:0]                 clr_r;
  logic [LB:0]                   cnt_r;
  logic                          rd_pend_r;
  logic [LB-1:0]                 rd_line_r;
  logic [LB-1:0]                 stage_r;
  logic [LB-1:0]                 k_r;
  logic                          req_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [IDX_BITS-1:0]           idx_r;
  logic [LEN_BITS-1:0]           dlen_r;
  logic signed [ACCB-1:0]        acc_r;
  logic                          sat_r;

  // Tap scale: round half up of cell*gain/65536
  logic signed [SAMPLE_BITS+GAIN_BITS:0] prod;
  logic signed [WB-1:0]                  tap;
  assign prod = $signed(mem_rdata_r) * $signed({1'b0, GAIN_BITS'(GAIN)})
              + (SAMPLE_BITS + GAIN_BITS + 1)'(32768);
  assign tap = WB'(prod >>> 16);

  // Butterfly pair at stage h, pair counter k
  logic [LB-1:0] h_val, bf_lo, bf_hi, low_mask;
  assign h_val    = LB'(1) << stage_r;
  assign low_mask = h_val - LB'(1);
  assign bf_lo    = ((k_r & ~low_mask) << 1) | (k_r & low_mask);
  assign bf_hi    = bf_lo | h_val;

  // Write-back value with clip
  logic [LB-1:0]           wr_line;
  logic signed [WB:0]      wsum;
  logic signed [SAMPLE_BITS-1:0] wclip;
  logic                    wsat;
  assign wr_line = cnt_r[LB-1:0];
  assign wsum = (WB+1)'(x_r) + (WB+1)'(mix_r[wr_line]);
  always_comb begin
    wsat = 1'b1;
    if (wsum > (WB+1)'(SMAX)) wclip = SAMPLE_BITS'(SMAX);
    else if (wsum < (WB+1)'(SMIN)) wclip = SAMPLE_BITS'(SMIN);
    else begin
      wclip = SAMPLE_BITS'(wsum);
      wsat  = 1'b0;
    end
  end

  // Output clip of the accumulator
  logic signed [SAMPLE_BITS-1:0] oclip;
  logic                          osat;
  always_comb begin
    osat = 1'b1;
    if (acc_r > ACCB'(SMAX)) oclip = SAMPLE_BITS'(SMAX);
    else if (acc_r < ACCB'(SMIN)) oclip = SAMPLE_BITS'(SMIN);
    else begin
      oclip = SAMPLE_BITS'(acc_r);
      osat  = 1'b0;
    end
  end

  // Load length: zero to one, clamp to MAX_DELAY-1
  logic [PB-1:0] ld_len;
  always_comb begin
    if (dlen_r == '0) ld_len = PB'(1);
    else if (32'(dlen_r) > MAX_DELAY - 1) ld_len = MAX_LEN;
    else ld_len = PB'(dlen_r);
  end

  // Memory address select
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = wclip;
    mem_addr  = {cnt_r[LB-1:0], rpos_r[cnt_r[LB-1:0]]};
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = clr_r;
      end
      S_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = {wr_line, wpos_r[wr_line]};
      end
      default: ;
    endcase
  end

  // Take a new item whenever idle; a waiting result is held in S_DONE
  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        rpos_r[i] <= '0;
        wpos_r[i] <= DEF_LEN;
        len_r[i]  <= DEF_LEN;
      end
    end else begin
      if (out_valid && out_ready && state_r != S_DONE) out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AB'(1);
          if (clr_r == AB'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r  <= in_req_type;
            x_r    <= in_in_sample;
            idx_r  <= in_line_index;
            dlen_r <= in_delay_length;
            acc_r  <= ACCB'(in_in_sample);
            sat_r  <= 1'b0;
            cnt_r  <= '0;
            rd_pend_r <= 1'b0;
            state_r <= (in_req_type == REQ_LOAD) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          // issue one read a cycle, absorb the previous one
          rd_pend_r <= !cnt_r[LB];
          rd_line_r <= cnt_r[LB-1:0];
          if (!cnt_r[LB]) cnt_r <= cnt_r + (LB+1)'(1);
          if (rd_pend_r) begin
            mix_r[rd_line_r] <= tap;
            acc_r <= acc_r + ACCB'(tap);
          end
          if (cnt_r[LB] && rd_pend_r) begin
            state_r <= S_MIX;
            stage_r <= '0;
            k_r     <= '0;
          end
        end
        S_MIX: begin
          mix_r[bf_lo] <= mix_r[bf_lo] + mix_r[bf_hi];
          mix_r[bf_hi] <= mix_r[bf_lo] - mix_r[bf_hi];
          if (k_r == LB'(NUM_LINES/2 - 1)) begin
            k_r <= '0;
            stage_r <= stage_r + LB'(1);
            if (stage_r == LB'(LB - 1)) begin
              state_r <= S_WRITE;
              cnt_r   <= '0;
            end
          end else begin
            k_r <= k_r + LB'(1);
          end
        end
        S_WRITE: begin
          if (wsat) sat_r <= 1'b1;
          wpos_r[wr_line] <= (wpos_r[wr_line] >= len_r[wr_line]) ? '0
                             : wpos_r[wr_line] + PB'(1);
          rpos_r[wr_line] <= (rpos_r[wr_line] >= len_r[wr_line]) ? '0
                             : rpos_r[wr_line] + PB'(1);
          cnt_r <= cnt_r + (LB+1)'(1);
          if (cnt_r == (LB+1)'(NUM_LINES - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (req_r == REQ_LOAD) begin
              out_out_sample <= '0;
              out_saturated  <= 1'b0;
              if (32'(idx_r) < NUM_LINES) begin
                len_r[idx_r[LB-1:0]]  <= ld_len;
                rpos_r[idx_r[LB-1:0]] <= '0;
                wpos_r[idx_r[LB-1:0]] <= ld_len;
              end
            end else begin
              out_out_sample <= oclip;
              out_saturated  <= sat_r | osat;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/hfdr_checker.sv
// ----------------------------------------------------------------------------
// hfdr_checker
// Port-level checks of the reverb block, bound to the top level.
// ----------------------------------------------------------------------------
`include "hadamard_feedback_delay_reverb_assert.svh"
module hfdr_checker
  import hfdr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_out_sample,
  input logic                   out_saturated
);
  // hold a stalled result
  `HFDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_out_sample) && $stable(out_saturated), "result dropped while stalled")
  // one item in work: no acceptance right after an acceptance
  `HFDR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "item accepted while busy")
  // a presented result carries known values
  `HFDR_ASSERT_ALWAYS(a_out_known, clk, rst_n, !out_valid || !$isunknown({out_out_sample, out_saturated}), "unknown result fields")
endmodule

bind hadamard_feedback_delay_reverb hfdr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_hfdr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_out_sample(out_out_sample), .out_saturated(out_saturated)
);
